// ===== hdl/fprx_pkg.sv =====
// Package with shared types, codes and the CRC-16 byte update for the framed packet receiver.
`timescale 1ns / 1ps

package fprx_pkg;

    localparam logic [7:0]  START_BYTE       = 8'h02;
    localparam logic [15:0] CRC_POLY         = 16'h1021;
    localparam logic [15:0] CRC_PRESET_RESET = 16'h00BD;
    localparam int          CFG_INDEX_W      = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OWN_ADDRESS = 1'b0,
        CFG_CRC_PRESET  = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_RESYNC  = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_ACCEPTED = 2'd1,
        EV_CRC_ERR  = 2'd2,
        EV_FOREIGN  = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_ADDR  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRC1  = 3'd5,
        PH_CRC2  = 3'd6,
        PH_IDLE  = 3'd7
    } t_phase;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        logic [7:0] frame_address;
    } t_result;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/framed_packet_receiver_crc16.sv =====
// Top level of the framed packet receiver: input register, parser core and result queue.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         i_in_valid / o_in_stall    i_cmd, i_data_byte
//   result   out        o_out_valid / i_out_stall  o_event_res .. o_frame_address
//   config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An item is registered on acceptance, then parsed by the core, and any result is registered
// in the result queue; one item per cycle is sustained while the result queue is not full.
// The rate is set by the combinational CRC byte update and phase change in the core.
// A two-entry result queue lets items keep flowing while a result waits to be taken.
// Reset is synchronous and active low; no clearing pass is needed.
`timescale 1ns / 1ps

module framed_packet_receiver_crc16 (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_cmd,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_event_res,
    output logic [7:0]                          o_payload_byte,
    output logic [7:0]                          o_byte_index,
    output logic [7:0]                          o_frame_length,
    output logic [7:0]                          o_frame_address,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fprx_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);
    import fprx_pkg::*;

    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic [7:0]  r_data_byte;
    logic [7:0]  r_own_address;
    logic [15:0] r_crc_preset;
    t_result     r_head, r_tail;
    logic [1:0]  r_cnt;

    logic        in_acc;
    logic        advance;
    logic        q_full;
    logic        pop;
    logic        res_valid;
    logic        push;
    t_result     res;

    assign q_full      = (r_cnt == 2'd2);
    assign advance     = r_in_valid && !q_full;
    assign o_in_stall  = r_in_valid && !advance;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_cnt != 2'd0);
    assign pop         = o_out_valid && !i_out_stall;
    assign push        = res_valid;

    assign o_event_res     = r_head.event_res;
    assign o_payload_byte  = r_head.payload_byte;
    assign o_byte_index    = r_head.byte_index;
    assign o_frame_length  = r_head.frame_length;
    assign o_frame_address = r_head.frame_address;

    fprx_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_cmd         (r_cmd),
        .i_data_byte   (r_data_byte),
        .i_own_address (r_own_address),
        .i_crc_preset  (r_crc_preset),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc || (r_in_valid && !advance);
        end
        if (in_acc) begin
            r_cmd       <= i_cmd;
            r_data_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= 8'd0;
            r_crc_preset  <= CRC_PRESET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OWN_ADDRESS: r_own_address <= i_cfg_data[7:0];
                CFG_CRC_PRESET:  r_crc_preset  <= i_cfg_data;
                default:         r_crc_preset  <= r_crc_preset;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (push && !pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (pop && !push) begin
            r_cnt <= r_cnt - 2'd1;
        end
        if (pop && push) begin
            if (r_cnt == 2'd1) begin
                r_head <= res;
            end else begin
                r_head <= r_tail;
                r_tail <= res;
            end
        end else if (pop) begin
            r_head <= r_tail;
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                r_head <= res;
            end else begin
                r_tail <= res;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("Result queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("Result pushed into a full queue");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && q_full)
        else $error("Input stalled without a waiting item and a full queue");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt != 2'd0))
        else $error("Queue empty after a push");
`endif

endmodule

// ===== hdl/fprx_core.sv =====
// Frame parser state machine with CRC-16 check, one item per enabled cycle.
`timescale 1ns / 1ps

module fprx_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_data_byte,
    input  logic [7:0]        i_own_address,
    input  logic [15:0]       i_crc_preset,
    output logic              o_res_valid,
    output fprx_pkg::t_result o_res
);
    import fprx_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_address, n_address;
    logic [7:0]  r_length, n_length;
    logic [7:0]  r_seen, n_seen;
    logic [15:0] r_crc, n_crc;
    logic [15:0] crc_next;
    logic [7:0]  seen_inc;
    logic        is_byte;

    assign is_byte  = i_en && (i_cmd == CMD_BYTE);
    assign crc_next = crc_fold((r_phase == PH_ADDR) ? i_crc_preset : r_crc, i_data_byte);
    assign seen_inc = r_seen + 8'd1;

    always_comb begin
        n_phase = r_phase;
        if (i_en) begin
            case (i_cmd)
                CMD_RESYNC, CMD_RESTART: begin
                    n_phase = PH_HUNT1;
                end
                CMD_BYTE: begin
                    case (r_phase)
                        PH_HUNT1: begin
                            if (i_data_byte == START_BYTE) n_phase = PH_HUNT2;
                        end
                        PH_HUNT2: begin
                            n_phase = (i_data_byte == START_BYTE) ? PH_ADDR : PH_HUNT1;
                        end
                        PH_ADDR: n_phase = PH_LEN;
                        PH_LEN: begin
                            n_phase = (i_data_byte == 8'd0) ? PH_CRC1 : PH_DATA;
                        end
                        PH_DATA: begin
                            if (seen_inc >= r_length) n_phase = PH_CRC1;
                        end
                        PH_CRC1: n_phase = PH_CRC2;
                        PH_CRC2: begin
                            if (crc_next != 16'd0 || r_address != i_own_address) begin
                                n_phase = PH_HUNT1;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                        default: n_phase = r_phase;
                    endcase
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    always_comb begin
        n_address   = r_address;
        n_length    = r_length;
        n_seen      = r_seen;
        n_crc       = r_crc;
        o_res_valid = 1'b0;
        o_res       = '{EV_PAYLOAD, 8'd0, 8'd0, r_length, r_address};
        if (is_byte) begin
            case (r_phase)
                PH_ADDR: begin
                    n_address = i_data_byte;
                    n_crc     = crc_next;
                end
                PH_LEN: begin
                    n_length = i_data_byte;
                    n_crc    = crc_next;
                    n_seen   = 8'd0;
                end
                PH_DATA: begin
                    n_crc              = crc_next;
                    n_seen             = seen_inc;
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_data_byte;
                    o_res.byte_index   = r_seen;
                end
                PH_CRC1: begin
                    n_crc = crc_next;
                end
                PH_CRC2: begin
                    n_crc       = crc_next;
                    o_res_valid = 1'b1;
                    if (crc_next != 16'd0) begin
                        o_res.event_res = EV_CRC_ERR;
                    end else if (r_address != i_own_address) begin
                        o_res.event_res = EV_FOREIGN;
                    end else begin
                        o_res.event_res = EV_ACCEPTED;
                    end
                end
                default: begin
                    n_crc = r_crc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT1;
            r_address <= 8'd0;
            r_length  <= 8'd0;
            r_seen    <= 8'd0;
            r_crc     <= 16'd0;
        end else begin
            r_phase   <= n_phase;
            r_address <= n_address;
            r_length  <= n_length;
            r_seen    <= n_seen;
            r_crc     <= n_crc;
        end
    end

endmodule
